// ===== rtl/rsort_pkg.sv =====
// Shared constants, command and status types, and key helpers for the radix sort order unit.
// No dependencies; every other file imports this package.
package rsort_pkg;

   localparam int MAX_ITEMS = 4096;
   localparam int AW        = $clog2(MAX_ITEMS);   // item address bits
   localparam int CW        = AW + 1;              // item count bits
   localparam int BUCKETS   = 2048;
   localparam int DW        = $clog2(BUCKETS);     // digit bits
   localparam int PASSES    = 6;
   localparam int PW        = 3;                   // pass number bits
   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

   localparam logic CSR_DESCENDING   = 1'b0;
   localparam logic CSR_RETURN_ORDER = 1'b1;

   typedef struct packed {
      logic          load;        // store the request beat
      logic          rd_req;      // read sorted position
      logic          out_load;    // move read data to output register
      logic          clr;         // clear all count banks at bucket
      logic          hist_rd;     // read source item
      logic          hist_cnt;    // read every bank at its digit
      logic          hist_wr;     // write incremented counts
      logic          pfx_start;   // clear running sums
      logic          pfx_rd;      // read every bank at bucket
      logic          pfx_wr;      // write running sums
      logic          sct_rd;      // read source item of a pass
      logic          sct_cnt;     // read the pass bank at the digit
      logic          sct_wr;      // write destination, bump the count
      logic          sorted_set;  // sort finished
      logic [AW-1:0] item_idx;
      logic [DW-1:0] bucket;
      logic [PW-1:0] pass;
   } cmd_type;

   typedef struct packed {
      logic [CW-1:0] item_count;
      logic          out_free;
   } stat_type;

   function automatic logic is_nan(input logic [63:0] v);
      return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
   endfunction

   // Order-preserving unsigned key of a double pattern.
   function automatic logic [63:0] key_of(input logic [63:0] v, input logic desc);
      logic [63:0] t;
      t = is_nan(v) ? (v | SIGN_BIT) : v;
      t = desc ? (t ^ SIGN_BIT) : t;
      return t[63] ? ~t : (t ^ SIGN_BIT);
   endfunction

   function automatic logic [DW-1:0] digit_of(input logic [63:0] key, input logic [PW-1:0] pass);
      logic [DW-1:0] d;
      unique case (pass)
         3'd0:    d = key[10:0];
         3'd1:    d = key[21:11];
         3'd2:    d = key[32:22];
         3'd3:    d = key[43:33];
         3'd4:    d = key[54:44];
         default: d = {2'b00, key[63:55]};
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/rsort_dp.sv =====
// Datapath of the radix sort order unit: item buffers, six count banks, running sums,
// configuration registers and the output register. Depends on rsort_pkg.
module rsort_dp (
   input  logic               clock,
   input  logic               reset,
   input  rsort_pkg::cmd_type cmd,
   output rsort_pkg::stat_type stat,
   input  logic [63:0]        req_value_bits,
   input  logic [11:0]        req_read_position,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic               csr_write_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_result_word
);
   import rsort_pkg::*;

   logic [63:0]   va_mem [MAX_ITEMS];
   logic [63:0]   vb_mem [MAX_ITEMS];
   logic [AW-1:0] ia_mem [MAX_ITEMS];
   logic [AW-1:0] ib_mem [MAX_ITEMS];

   logic [63:0]   va_rd_ff, vb_rd_ff;
   logic [AW-1:0] ia_rd_ff, ib_rd_ff;
   logic [CW-1:0] cnt_rd_ff [PASSES];
   logic [CW-1:0] sum_ff [PASSES];
   logic [CW-1:0] sum_in [PASSES];

   logic [CW-1:0] count_ff, count_in;
   logic          sorted_ff, sorted_in;
   logic          desc_ff, ret_ff;
   logic          pos_ok_ff, rd_ret_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_word_ff;

   logic [CW-1:0] load_base;
   logic          src_b;
   logic [63:0]   src_val;
   logic [AW-1:0] src_idx;
   logic [63:0]   src_key;
   logic [AW-1:0] dst_addr;
   logic [AW-1:0] rd_addr_a;
   logic          wr_a, wr_b;
   logic [AW-1:0] wr_addr_a;
   logic [63:0]   wr_val_a;
   logic [AW-1:0] wr_idx_a;
   logic [63:0]   out_val;

   assign src_b   = cmd.pass[0];
   assign src_val = src_b ? vb_rd_ff : va_rd_ff;
   assign src_idx = src_b ? ib_rd_ff : ia_rd_ff;
   assign src_key = key_of(src_val, desc_ff);
   assign dst_addr = cnt_rd_ff[cmd.pass][AW-1:0];

   // a first load after a sort starts a new batch
   assign load_base = sorted_ff ? '0 : count_ff;

   always_comb begin
      count_in  = count_ff;
      sorted_in = sorted_ff;
      if (cmd.load) begin
         sorted_in = 1'b0;
         count_in  = load_base;
         if (load_base < CW'(MAX_ITEMS)) begin
            count_in = load_base + CW'(1);
         end
      end
      if (cmd.sorted_set) begin
         sorted_in = 1'b1;
      end
   end

   assign rd_addr_a = cmd.rd_req ? req_read_position : cmd.item_idx;
   assign wr_a      = (cmd.load && (load_base < CW'(MAX_ITEMS))) || (cmd.sct_wr && src_b);
   assign wr_b      = cmd.sct_wr && !src_b;
   assign wr_addr_a = cmd.load ? load_base[AW-1:0] : dst_addr;
   assign wr_val_a  = cmd.load ? req_value_bits : src_val;
   assign wr_idx_a  = cmd.load ? load_base[AW-1:0] : src_idx;

   always_ff @(posedge clock) begin
      if (wr_a) begin
         va_mem[wr_addr_a] <= wr_val_a;
         ia_mem[wr_addr_a] <= wr_idx_a;
      end
      if (cmd.rd_req || cmd.hist_rd || (cmd.sct_rd && !src_b)) begin
         va_rd_ff <= va_mem[rd_addr_a];
         ia_rd_ff <= ia_mem[rd_addr_a];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         vb_mem[dst_addr] <= src_val;
         ib_mem[dst_addr] <= src_idx;
      end
      if (cmd.sct_rd && src_b) begin
         vb_rd_ff <= vb_mem[cmd.item_idx];
         ib_rd_ff <= ib_mem[cmd.item_idx];
      end
   end

   for (genvar b = 0; b < PASSES; b++) begin : g_bank
      logic [CW-1:0] bank_mem [BUCKETS];
      logic [DW-1:0] addr;
      logic          rd_en, wr_en, this_pass;
      logic [CW-1:0] wdata;

      assign this_pass = (cmd.pass == PW'(b));
      assign addr  = (cmd.clr || cmd.pfx_rd || cmd.pfx_wr) ? cmd.bucket
                                                           : digit_of(src_key, PW'(b));
      assign rd_en = cmd.hist_cnt || cmd.pfx_rd || (cmd.sct_cnt && this_pass);
      assign wr_en = cmd.clr || cmd.hist_wr || cmd.pfx_wr || (cmd.sct_wr && this_pass);

      always_comb begin
         if (cmd.clr) begin
            wdata = '0;
         end else if (cmd.pfx_wr) begin
            wdata = sum_ff[b];
         end else begin
            wdata = cnt_rd_ff[b] + CW'(1);
         end
      end

      always_comb begin
         sum_in[b] = sum_ff[b];
         if (cmd.pfx_start) begin
            sum_in[b] = '0;
         end else if (cmd.pfx_wr) begin
            sum_in[b] = sum_ff[b] + cnt_rd_ff[b];
         end
      end

      always_ff @(posedge clock) begin
         if (wr_en) begin
            bank_mem[addr] <= wdata;
         end
         if (rd_en) begin
            cnt_rd_ff[b] <= bank_mem[addr];
         end
         sum_ff[b] <= sum_in[b];
      end
   end

   // NaN comes back with its forced sign bit once sorted
   assign out_val = (sorted_ff && is_nan(va_rd_ff)) ? (va_rd_ff | SIGN_BIT) : va_rd_ff;

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sorted_ff    <= 1'b0;
         desc_ff      <= 1'b0;
         ret_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sorted_ff    <= sorted_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DESCENDING:   desc_ff <= csr_write_data;
               CSR_RETURN_ORDER: ret_ff  <= csr_write_data;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_req) begin
         pos_ok_ff <= {1'b0, req_read_position} < count_ff;
         rd_ret_ff <= ret_ff;
      end
      if (cmd.out_load) begin
         if (!pos_ok_ff) begin
            rsp_word_ff <= '0;
         end else if (rd_ret_ff) begin
            rsp_word_ff <= 64'({1'b0, ia_rd_ff} + CW'(1));
         end else begin
            rsp_word_ff <= out_val;
         end
      end
   end

   assign stat.item_count = count_ff;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = rsp_word_ff;

endmodule

// ===== rtl/rsort_ctrl.sv =====
// Sequencer of the radix sort order unit: clear, histogram, prefix and scatter phases.
// Depends on rsort_pkg; drives rsort_dp through the command struct.
module rsort_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_func,
   input  logic                req_last,
   input  rsort_pkg::stat_type stat,
   output rsort_pkg::cmd_type  cmd
);
   import rsort_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_READ     = 11'b000_0000_0010,
      S_CLR      = 11'b000_0000_0100,
      S_HIST_RD  = 11'b000_0000_1000,
      S_HIST_CNT = 11'b000_0001_0000,
      S_HIST_WR  = 11'b000_0010_0000,
      S_PFX_RD   = 11'b000_0100_0000,
      S_PFX_WR   = 11'b000_1000_0000,
      S_SCT_RD   = 11'b001_0000_0000,
      S_SCT_CNT  = 11'b010_0000_0000,
      S_SCT_WR   = 11'b100_0000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] item_ff, item_in;
   logic [DW-1:0] bucket_ff, bucket_in;
   logic [PW-1:0] pass_ff, pass_in;
   logic          accept, last_item, last_bucket;

   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign last_item   = ({1'b0, item_ff} + CW'(1)) == stat.item_count;
   assign last_bucket = (bucket_ff == DW'(BUCKETS - 1));

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      bucket_in = bucket_ff;
      pass_in   = pass_ff;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_func) begin
               cmd.rd_req = 1'b1;
               state_in   = S_READ;
            end else if (accept) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  bucket_in = '0;
                  pass_in   = '0;
                  item_in   = '0;
                  state_in  = S_CLR;
               end
            end
         end
         S_READ: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_CLR: begin
            cmd.clr   = 1'b1;
            bucket_in = bucket_ff + DW'(1);
            if (last_bucket) begin
               if (stat.item_count == '0) begin
                  cmd.sorted_set = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  state_in = S_HIST_RD;
               end
            end
         end
         S_HIST_RD: begin
            cmd.hist_rd = 1'b1;
            state_in    = S_HIST_CNT;
         end
         S_HIST_CNT: begin
            cmd.hist_cnt = 1'b1;
            state_in     = S_HIST_WR;
         end
         S_HIST_WR: begin
            cmd.hist_wr = 1'b1;
            if (last_item) begin
               cmd.pfx_start = 1'b1;
               item_in       = '0;
               bucket_in     = '0;
               state_in      = S_PFX_RD;
            end else begin
               item_in  = item_ff + AW'(1);
               state_in = S_HIST_RD;
            end
         end
         S_PFX_RD: begin
            cmd.pfx_rd = 1'b1;
            state_in   = S_PFX_WR;
         end
         S_PFX_WR: begin
            cmd.pfx_wr = 1'b1;
            bucket_in  = bucket_ff + DW'(1);
            state_in   = last_bucket ? S_SCT_RD : S_PFX_RD;
         end
         S_SCT_RD: begin
            cmd.sct_rd = 1'b1;
            state_in   = S_SCT_CNT;
         end
         S_SCT_CNT: begin
            cmd.sct_cnt = 1'b1;
            state_in    = S_SCT_WR;
         end
         S_SCT_WR: begin
            cmd.sct_wr = 1'b1;
            if (last_item) begin
               item_in = '0;
               if (pass_ff == PW'(PASSES - 1)) begin
                  cmd.sorted_set = 1'b1;
                  pass_in        = '0;
                  state_in       = S_IDLE;
               end else begin
                  pass_in  = pass_ff + PW'(1);
                  state_in = S_SCT_RD;
               end
            end else begin
               item_in  = item_ff + AW'(1);
               state_in = S_SCT_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
      cmd.item_idx = item_ff;
      cmd.bucket   = bucket_ff;
      cmd.pass     = pass_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         item_ff   <= '0;
         bucket_ff <= '0;
         pass_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         item_ff   <= item_in;
         bucket_ff <= bucket_in;
         pass_ff   <= pass_in;
      end
   end

endmodule

// ===== rtl/float64_radix_sort_order_unit.sv =====
// Channel  Ports                                   Direction
// req      req_valid/req_stall, func..read_position in
// rsp      rsp_valid/rsp_stall, rsp_result_word     out
// csr      csr_write_enable, csr_index, data        in
//
// A load beat is stored in the idle state; a read fetches the item, then waits out any output stall.
// The last load runs the sort: it clears the count banks bucket by bucket, builds the
// histogram item by item, forms the prefix sums bucket by bucket and runs six scatter
// passes over the items.
// req_stall stays high while a read or the sort runs; reset is synchronous.
// Top level of the radix sort order unit; depends on rsort_pkg, rsort_ctrl and rsort_dp.
module float64_radix_sort_order_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [63:0] req_value_bits,
   input  logic        req_last,
   input  logic [11:0] req_read_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_word,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic        csr_write_data
);
   import rsort_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rsort_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .req_last  (req_last),
      .stat      (stat),
      .cmd       (cmd)
   );

   rsort_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_value_bits    (req_value_bits),
      .req_read_position (req_read_position),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_word   (rsp_result_word)
   );

   // never overwrite a beat that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.out_load && rsp_valid && rsp_stall))
      else $error("output beat overwritten");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load))
      else $error("result beat without read");

   a_load_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !(cmd.sct_wr || cmd.clr || cmd.hist_wr || cmd.pfx_wr))
      else $error("load collides with sort write");

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for float64_radix_sort_order_unit: batches of loads, sorts, reads.
// Carries its own ordering predictor; needs rsort_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb;
   import rsort_pkg::*;

   typedef struct {
      logic        func;
      logic [63:0] value;
      logic        last;
      logic [11:0] pos;
   } beat_type;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = FUNC_LOAD;
   logic [63:0] req_value_bits = '0;
   logic        req_last = 1'b0;
   logic [11:0] req_read_position = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_result_word;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_DESCENDING;
   logic        csr_write_data = 1'b0;

   float64_radix_sort_order_unit uut (.*);

   always #2 clock = ~clock;

   // predictor state
   logic [63:0] held_value[MAX_ITEMS];
   logic [11:0] held_index[MAX_ITEMS];
   int          held_count = 0;
   bit          batch_sorted = 0;
   bit          desc_mode = 0;
   bit          index_mode = 0;

   beat_type    pending_beats[$];
   logic [63:0] expected_words[$];
   bit          calm = 0;
   bit          failed = 0;
   bit          took = 0;
   int          req_gap = 0;
   int          rsp_gap = 0;
   int          items_sent = 0;
   logic [63:0] dup_pool[4];

   function automatic logic [63:0] ordered_key(input logic [63:0] v);
      logic [63:0] t;
      t = v;
      if (t[62:52] == 11'h7FF && t[51:0] != 0) t[63] = 1'b1;
      if (desc_mode) t[63] = ~t[63];
      return t[63] ? ~t : {~t[63], t[62:0]};
   endfunction

   // Stable byte-wise LSD ordering of the held batch; NaNs keep the forced sign.
   task automatic sort_batch();
      logic [63:0] ka[MAX_ITEMS], kb[MAX_ITEMS], va[MAX_ITEMS], vb[MAX_ITEMS];
      logic [11:0] ia[MAX_ITEMS], ib[MAX_ITEMS];
      int          bucket_base[256];
      int          sum, c, d;
      for (int i = 0; i < held_count; i++) begin
         ka[i] = ordered_key(held_value[i]);
         va[i] = held_value[i];
         if (va[i][62:52] == 11'h7FF && va[i][51:0] != 0) va[i][63] = 1'b1;
         ia[i] = held_index[i];
      end
      for (int p = 0; p < 8; p++) begin
         for (int b = 0; b < 256; b++) bucket_base[b] = 0;
         for (int i = 0; i < held_count; i++) bucket_base[(ka[i] >> (8 * p)) & 255]++;
         sum = 0;
         for (int b = 0; b < 256; b++) begin
            c = bucket_base[b];
            bucket_base[b] = sum;
            sum += c;
         end
         for (int i = 0; i < held_count; i++) begin
            d = bucket_base[(ka[i] >> (8 * p)) & 255]++;
            kb[d] = ka[i];
            vb[d] = va[i];
            ib[d] = ia[i];
         end
         ka = kb;
         va = vb;
         ia = ib;
      end
      for (int i = 0; i < held_count; i++) begin
         held_value[i] = va[i];
         held_index[i] = ia[i];
      end
      batch_sorted = 1;
   endtask

   task automatic apply_beat(input beat_type b);
      if (b.func == FUNC_LOAD) begin
         if (batch_sorted) begin
            batch_sorted = 0;
            held_count = 0;
         end
         if (held_count < MAX_ITEMS) begin
            held_value[held_count] = b.value;
            held_index[held_count] = held_count[11:0];
            held_count++;
         end
         if (b.last) sort_batch();
      end else if (b.pos < held_count) begin
         expected_words.push_back(index_mode ? 64'(held_index[b.pos]) + 64'd1
                                             : held_value[b.pos]);
      end else begin
         expected_words.push_back(64'd0);
      end
   endtask

   // accept and predict
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         apply_beat('{req_func, req_value_bits, req_last, req_read_position});
         took = 1;
      end
   end

   // request driver
   always @(negedge clock) begin
      beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || took) begin
         took = 0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
            req_gap = $urandom_range(0, 2);
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            b = pending_beats.pop_front();
            req_func <= b.func;
            req_value_bits <= b.value;
            req_last <= b.last;
            req_read_position <= b.pos;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_gap = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // result checker
   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t unexpected beat: expected none actual %h", $time, rsp_result_word);
            failed = 1;
         end else begin
            want = expected_words.pop_front();
            if (rsp_result_word !== want) begin
               $display("%0t result_word mismatch: expected %h actual %h",
                        $time, want, rsp_result_word);
               failed = 1;
            end
         end
      end
   end

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 64'h0000_0000_0000_0000;
         1: return SIGN_BIT;
         2: return $urandom_range(0, 1) ? 64'h7FF0_0000_0000_0000 : 64'hFFF0_0000_0000_0000;
         3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 11'h7FF,
                    52'(1 + $urandom_range(0, 1000))};
         4: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 11'h000, 20'd0, 32'($urandom)};
         5, 6: return dup_pool[$urandom_range(0, 3)];
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic add_load(input logic [63:0] v, input logic last);
      pending_beats.push_back('{FUNC_LOAD, v, last, 12'($urandom)});
      items_sent++;
   endtask

   task automatic add_read(input logic [11:0] p);
      pending_beats.push_back('{FUNC_READ, {$urandom, $urandom}, 1'($urandom_range(0, 1)), p});
      items_sent++;
   endtask

   task automatic drain();
      wait (pending_beats.size() == 0 && !req_valid && expected_words.size() == 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input bit val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      if (idx == CSR_DESCENDING) desc_mode = val;
      else index_mode = val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_batch();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
      for (int i = 0; i < n; i++) begin
         add_load(pick_value(), i == n - 1);
         // occasional read into the batch being loaded, or into the sorted one after the last load
         if ($urandom_range(0, 15) == 0) add_read(12'($urandom_range(0, i + 1)));
      end
      for (int i = 0, r = $urandom_range(3, 30); i < r; i++)
         add_read($urandom_range(0, 7) == 0 ? 12'($urandom) : 12'($urandom_range(0, n - 1)));
   endtask

   initial begin
      for (int i = 0; i < 4; i++) dup_pool[i] = {$urandom, $urandom};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: read before any sort, specials, one-item batch
      add_read(12'd0);
      add_load(64'h7FF0_0000_0000_07A2, 1'b0);
      add_load(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      add_load(SIGN_BIT, 1'b0);
      add_read(12'd1);
      add_load(64'h0000_0000_0000_0000, 1'b0);
      add_load(64'h7FF0_0000_0000_0000, 1'b0);
      add_load(64'hFFF0_0000_0000_0000, 1'b0);
      add_load(64'h0000_0000_0000_0001, 1'b0);
      add_load(64'h800F_FFFF_FFFF_FFFF, 1'b0);
      add_load(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
      add_load(64'h3FF0_0000_0000_0000, 1'b0);
      add_load(64'h3FF0_0000_0000_0000, 1'b1);
      for (int i = 0; i < 12; i++) add_read(12'(i));
      add_read(12'hFFF);
      add_load(64'h7FF8_0000_0000_0000, 1'b1);
      add_read(12'd0);
      add_read(12'd1);
      drain();

      write_reg(CSR_DESCENDING, 1'b1);
      write_reg(CSR_RETURN_ORDER, 1'b1);
      add_load(64'h7FF8_0000_0000_0000, 1'b0);
      add_load(64'hBFF0_0000_0000_0000, 1'b0);
      add_load(64'hBFF0_0000_0000_0000, 1'b0);
      add_load(64'h0000_0000_0000_0000, 1'b0);
      add_load(SIGN_BIT, 1'b1);
      for (int i = 0; i < 6; i++) add_read(12'(i));
      drain();

      while (items_sent < 1700) begin
         if (items_sent > 1400) calm = 1;
         write_reg(CSR_DESCENDING, 1'($urandom_range(0, 1)));
         write_reg(CSR_RETURN_ORDER, 1'($urandom_range(0, 1)));
         random_batch();
         drain();
      end
      repeat (100) @(posedge clock);
      if (failed) $display("RESULT: ERROR");
      else $display("RESULT: OK");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
